// ===== rtl/core/fbr_pkg.sv =====
// Shared types, constants and helper functions of the raster drawing engine.
package fbr_pkg;

   // Default framebuffer geometry
   localparam int MAX_WIDTH_DEF  = 256;
   localparam int MAX_HEIGHT_DEF = 256;

   // Field widths
   localparam int FW      = 12;        // signed coordinate field
   localparam int CW      = FW + 1;    // internal coordinate, with headroom
   localparam int REG_W   = 9;
   localparam int COLOR_W = 24;
   localparam int CNT_W   = 17;
   localparam int RAD_W   = 10;
   localparam int OP_W    = 3;
   localparam int CX_W    = RAD_W + 1; // circle step x, may pass radius by one
   localparam int SQ_W    = 2 * RAD_W; // radius squared

   // Pipeline drain length after the last point
   localparam logic [1:0] DRAIN_LAST = 2'd1;

   typedef enum logic [OP_W-1:0] {
      OP_WRITE  = 3'd0,
      OP_READ   = 3'd1,
      OP_BOX    = 3'd2,
      OP_HSPAN  = 3'd3,
      OP_VSPAN  = 3'd4,
      OP_CIRCLE = 3'd5
   } op_type;

   typedef enum logic {
      CSR_WIDTH  = 1'b0,
      CSR_HEIGHT = 1'b1
   } csr_index_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_PIXEL,
      ST_BOX,
      ST_RASTER,
      ST_CIR_SQ,
      ST_CIR_AXIS,
      ST_CIR_INIT,
      ST_CIR_ROOT,
      ST_CIR_OCT,
      ST_CIR_QUAD,
      ST_DRAIN,
      ST_FINISH
   } state_type;

   typedef enum logic [1:0] {
      PT_A,
      PT_RASTER,
      PT_CIRCLE
   } pt_sel_type;

   // Controller to datapath
   typedef struct packed {
      logic       start;
      logic       box_setup;
      logic       col_step;
      logic       row_step;
      logic       square;
      logic       cir_init;
      logic       root_dec;
      logic       x_step;
      logic       emit;
      logic       is_read;
      pt_sel_type pt_sel;
      logic [2:0] oct;
      logic       load_rsp;
   } ctrl_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic r_zero;
      logic x_end;
      logic y_end;
      logic root_more;
      logic x_lt_y;
      logic x_eq_y;
      logic rsp_busy;
   } dp_status_type;

   function automatic logic signed [CW-1:0] sext_coord(input logic signed [FW-1:0] v);
      return {v[FW-1], v};
   endfunction

   function automatic logic signed [CW-1:0] clamp_coord(input logic signed [CW-1:0] v,
                                                         input logic signed [CW-1:0] hi);
      logic signed [CW-1:0] r;
      if (v < 0) r = '0;
      else if (v > hi) r = hi;
      else r = v;
      return r;
   endfunction

endpackage

// ===== rtl/core/fbr_if.sv =====
// Request and response channel interfaces of the raster drawing engine.
interface fbr_req_if import fbr_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [OP_W-1:0]       req_type;
   logic signed [FW-1:0]  x_a;
   logic signed [FW-1:0]  y_a;
   logic signed [FW-1:0]  x_b;
   logic signed [FW-1:0]  y_b;
   logic [RAD_W-1:0]      radius;
   logic [COLOR_W-1:0]    color;

   modport source (output valid, req_type, x_a, y_a, x_b, y_b, radius, color, input ready);
   modport sink   (input valid, req_type, x_a, y_a, x_b, y_b, radius, color, output ready);
endinterface

interface fbr_rsp_if import fbr_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [COLOR_W-1:0] read_color;
   logic [CNT_W-1:0]   pixels_written;

   modport source (output valid, read_color, pixels_written, input ready);
   modport sink   (input valid, read_color, pixels_written, output ready);
endinterface

// ===== rtl/core/fbr_ram.sv =====
// Generic single-port RAM with registered read data.
module fbr_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 65536,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic             re,
   input  logic [AW-1:0]    addr,
   input  logic [WIDTH-1:0] wdata,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Write or read one word
   always_ff @(posedge clock) begin
      if (we) mem_ff[addr] <= wdata;
      if (re) rdata_ff <= mem_ff[addr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== rtl/core/fbr_ctrl.sv =====
// Command sequencer of the raster drawing engine.
module fbr_ctrl import fbr_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic [OP_W-1:0]  req_type,
   output logic             req_ready,
   input  dp_status_type    status,
   output ctrl_cmd_type     cmd
);

   state_type  state_ff, state_in;
   op_type     op_ff, op_in;
   logic [2:0] sub_ff, sub_in;
   logic [1:0] drain_ff, drain_in;

   // Hold state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         op_ff    <= OP_WRITE;
         sub_ff   <= '0;
         drain_ff <= '0;
      end else begin
         state_ff <= state_in;
         op_ff    <= op_in;
         sub_ff   <= sub_in;
         drain_ff <= drain_in;
      end
   end

   // Next state and commands
   always_comb begin
      state_in  = state_ff;
      op_in     = op_ff;
      sub_in    = sub_ff;
      drain_in  = drain_ff;
      req_ready = 1'b0;
      cmd       = '0;
      cmd.pt_sel = PT_A;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.start = 1'b1;
               op_in     = op_type'(req_type);
               case (op_type'(req_type)) inside
                  OP_WRITE, OP_READ:           state_in = ST_PIXEL;
                  OP_BOX, OP_HSPAN, OP_VSPAN:  state_in = ST_BOX;
                  OP_CIRCLE:                   state_in = ST_CIR_SQ;
                  default:                     state_in = ST_FINISH;
               endcase
            end
         end
         ST_PIXEL: begin
            cmd.emit    = 1'b1;
            cmd.pt_sel  = PT_A;
            cmd.is_read = (op_ff == OP_READ);
            drain_in    = '0;
            state_in    = ST_DRAIN;
         end
         ST_BOX: begin
            cmd.box_setup = 1'b1;
            state_in      = ST_RASTER;
         end
         ST_RASTER: begin
            cmd.emit   = 1'b1;
            cmd.pt_sel = PT_RASTER;
            if (status.x_end) begin
               if (status.y_end) begin
                  drain_in = '0;
                  state_in = ST_DRAIN;
               end else begin
                  cmd.row_step = 1'b1;
               end
            end else begin
               cmd.col_step = 1'b1;
            end
         end
         ST_CIR_SQ: begin
            cmd.square = 1'b1;
            sub_in     = '0;
            state_in   = status.r_zero ? ST_PIXEL : ST_CIR_AXIS;
         end
         ST_CIR_AXIS: begin
            // axis points: (0,r) (0,-r) (r,0) (-r,0)
            cmd.emit   = 1'b1;
            cmd.pt_sel = PT_CIRCLE;
            case (sub_ff[1:0])
               2'd0:    cmd.oct = 3'd0;
               2'd1:    cmd.oct = 3'd1;
               2'd2:    cmd.oct = 3'd4;
               default: cmd.oct = 3'd6;
            endcase
            if (sub_ff[1:0] == 2'd3) state_in = ST_CIR_INIT;
            else sub_in = sub_ff + 3'd1;
         end
         ST_CIR_INIT: begin
            cmd.cir_init = 1'b1;
            state_in     = ST_CIR_ROOT;
         end
         ST_CIR_ROOT: begin
            sub_in = '0;
            if (status.root_more) begin
               cmd.root_dec = 1'b1;
            end else if (status.x_lt_y) begin
               state_in = ST_CIR_OCT;
            end else if (status.x_eq_y) begin
               state_in = ST_CIR_QUAD;
            end else begin
               drain_in = '0;
               state_in = ST_DRAIN;
            end
         end
         ST_CIR_OCT: begin
            cmd.emit   = 1'b1;
            cmd.pt_sel = PT_CIRCLE;
            cmd.oct    = sub_ff;
            if (sub_ff == 3'd7) begin
               cmd.x_step = 1'b1;
               state_in   = ST_CIR_ROOT;
            end else begin
               sub_in = sub_ff + 3'd1;
            end
         end
         ST_CIR_QUAD: begin
            cmd.emit   = 1'b1;
            cmd.pt_sel = PT_CIRCLE;
            cmd.oct    = sub_ff;
            if (sub_ff == 3'd3) begin
               drain_in = '0;
               state_in = ST_DRAIN;
            end else begin
               sub_in = sub_ff + 3'd1;
            end
         end
         ST_DRAIN: begin
            if (drain_ff == DRAIN_LAST) state_in = ST_FINISH;
            else drain_in = drain_ff + 2'd1;
         end
         ST_FINISH: begin
            if (!status.rsp_busy) begin
               cmd.load_rsp = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

// ===== rtl/core/fbr_datapath.sv =====
// Datapath: registers, point generation, pixel pipeline and framebuffer.
module fbr_datapath import fbr_pkg::*; #(
   parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [OP_W-1:0]      req_type,
   input  logic signed [FW-1:0] x_a,
   input  logic signed [FW-1:0] y_a,
   input  logic signed [FW-1:0] x_b,
   input  logic signed [FW-1:0] y_b,
   input  logic [RAD_W-1:0]     radius,
   input  logic [COLOR_W-1:0]   color,
   input  logic                 csr_we,
   input  logic                 csr_index,
   input  logic [REG_W-1:0]     csr_wdata,
   input  ctrl_cmd_type         cmd,
   output dp_status_type        status,
   input  logic                 rsp_ready,
   output logic                 rsp_valid,
   output logic [COLOR_W-1:0]   read_color,
   output logic [CNT_W-1:0]     pixels_written
);

   localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic [REG_W-1:0]     img_width_ff, img_height_ff;
   op_type               op_ff;
   logic signed [FW-1:0] xa_ff, ya_ff, xb_ff, yb_ff;
   logic [RAD_W-1:0]     radius_ff;
   logic [COLOR_W-1:0]   color_ff;
   logic signed [CW-1:0] x_lo_ff, x_hi_ff, y_lo_ff, y_hi_ff, cur_x_ff, cur_y_ff;
   logic [CX_W-1:0]      circ_x_ff;
   logic [RAD_W-1:0]     circ_y_ff;
   logic [SQ_W-1:0]      r2_ff, v_ff, t_ff;
   logic                 pt_valid_ff, pt_read_ff;
   logic signed [CW-1:0] px_ff, py_ff;
   logic                 wr_ff, re_ff;
   logic [AW-1:0]        addr_ff;
   logic [CNT_W-1:0]     cnt_ff;
   logic                 rd_hit_ff;
   logic                 rsp_valid_ff;
   logic [COLOR_W-1:0]   rsp_color_ff;
   logic [CNT_W-1:0]     rsp_cnt_ff;

   logic [CW-1:0]        w_eff, h_eff;
   logic signed [CW-1:0] wm, hm;
   logic signed [CW-1:0] ax, bx, ay, by, lox, hix, loy, hiy;
   logic signed [CW-1:0] px_in, py_in;
   logic [CX_W-1:0]      mag_a, mag_b;
   logic signed [CW-1:0] off_a, off_b;
   logic                 pt_on_image;
   logic [2*CW-1:0]      addr_full;
   logic [COLOR_W-1:0]   ram_rdata;

   // Clamp the image size into [1, max]
   always_comb begin
      if (img_width_ff == '0) w_eff = CW'(1);
      else if (CW'(img_width_ff) > CW'(MAX_WIDTH)) w_eff = CW'(MAX_WIDTH);
      else w_eff = CW'(img_width_ff);
      if (img_height_ff == '0) h_eff = CW'(1);
      else if (CW'(img_height_ff) > CW'(MAX_HEIGHT)) h_eff = CW'(MAX_HEIGHT);
      else h_eff = CW'(img_height_ff);
   end
   assign wm = $signed(w_eff - CW'(1));
   assign hm = $signed(h_eff - CW'(1));

   // Box bounds: spans are boxes one row or one column thick
   assign ax  = sext_coord(xa_ff);
   assign bx  = (op_ff == OP_VSPAN) ? sext_coord(xa_ff) : sext_coord(xb_ff);
   assign ay  = sext_coord(ya_ff);
   assign by  = (op_ff == OP_HSPAN) ? sext_coord(ya_ff) : sext_coord(yb_ff);
   assign lox = (ax < bx) ? ax : bx;
   assign hix = (ax < bx) ? bx : ax;
   assign loy = (ay < by) ? ay : by;
   assign hiy = (ay < by) ? by : ay;

   // Circle offsets for the eight symmetric points
   assign mag_a = cmd.oct[2] ? CX_W'(circ_y_ff) : circ_x_ff;
   assign mag_b = cmd.oct[2] ? circ_x_ff : CX_W'(circ_y_ff);
   assign off_a = cmd.oct[1] ? -$signed(CW'(mag_a)) : $signed(CW'(mag_a));
   assign off_b = cmd.oct[0] ? -$signed(CW'(mag_b)) : $signed(CW'(mag_b));

   // Select the point to plot
   always_comb begin
      case (cmd.pt_sel)
         PT_A: begin
            px_in = sext_coord(xa_ff);
            py_in = sext_coord(ya_ff);
         end
         PT_RASTER: begin
            px_in = cur_x_ff;
            py_in = cur_y_ff;
         end
         PT_CIRCLE: begin
            px_in = sext_coord(xa_ff) + off_a;
            py_in = sext_coord(ya_ff) + off_b;
         end
         default: begin
            px_in = '0;
            py_in = '0;
         end
      endcase
   end

   // Bounds check and word address of the staged point
   assign pt_on_image = !px_ff[CW-1] && !py_ff[CW-1] &&
                        ($unsigned(px_ff) < w_eff) && ($unsigned(py_ff) < h_eff);
   assign addr_full = (2*CW)'($unsigned(py_ff)) * (2*CW)'(w_eff) +
                      (2*CW)'($unsigned(px_ff));

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         img_width_ff  <= REG_W'(256);
         img_height_ff <= REG_W'(256);
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_WIDTH:  img_width_ff  <= csr_wdata;
            CSR_HEIGHT: img_height_ff <= csr_wdata;
            default:    ;
         endcase
      end
   end

   // Capture the command beat, then walk the shape
   always_ff @(posedge clock) begin
      if (cmd.start) begin
         op_ff     <= op_type'(req_type);
         xa_ff     <= x_a;
         ya_ff     <= y_a;
         xb_ff     <= x_b;
         yb_ff     <= y_b;
         radius_ff <= radius;
         color_ff  <= color;
         circ_x_ff <= '0;
         circ_y_ff <= radius;
      end
      if (cmd.box_setup) begin
         x_lo_ff  <= clamp_coord(lox, wm);
         x_hi_ff  <= clamp_coord(hix, wm);
         y_lo_ff  <= clamp_coord(loy, hm);
         y_hi_ff  <= clamp_coord(hiy, hm);
         cur_x_ff <= clamp_coord(lox, wm);
         cur_y_ff <= clamp_coord(loy, hm);
      end
      if (cmd.col_step) cur_x_ff <= cur_x_ff + CW'(1);
      if (cmd.row_step) begin
         cur_x_ff <= x_lo_ff;
         cur_y_ff <= cur_y_ff + CW'(1);
      end
      if (cmd.square) r2_ff <= SQ_W'(radius_ff) * SQ_W'(radius_ff);
      if (cmd.cir_init) begin
         circ_x_ff <= CX_W'(1);
         v_ff      <= r2_ff - SQ_W'(1);
         t_ff      <= r2_ff - SQ_W'(radius_ff);
      end
      // y(y-1) drops by 2(y-1) when y steps down
      if (cmd.root_dec) begin
         t_ff      <= t_ff - SQ_W'({circ_y_ff - RAD_W'(1), 1'b0});
         circ_y_ff <= circ_y_ff - RAD_W'(1);
      end
      // r^2 - x^2 drops by 2x+1 when x steps up
      if (cmd.x_step) begin
         v_ff      <= v_ff - SQ_W'({circ_x_ff, 1'b1});
         circ_x_ff <= circ_x_ff + CX_W'(1);
      end
   end

   // Pixel pipeline control
   always_ff @(posedge clock) begin
      if (reset) begin
         pt_valid_ff  <= 1'b0;
         wr_ff        <= 1'b0;
         re_ff        <= 1'b0;
         cnt_ff       <= '0;
         rd_hit_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pt_valid_ff <= cmd.emit;
         wr_ff       <= pt_valid_ff && !pt_read_ff && pt_on_image;
         re_ff       <= pt_valid_ff && pt_read_ff && pt_on_image;
         if (cmd.start) begin
            cnt_ff    <= '0;
            rd_hit_ff <= 1'b0;
         end else begin
            if (pt_valid_ff && !pt_read_ff && pt_on_image) cnt_ff <= cnt_ff + CNT_W'(1);
            if (pt_valid_ff && pt_read_ff) rd_hit_ff <= pt_on_image;
         end
         if (cmd.load_rsp) rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
      end
   end

   // Pixel pipeline payload and result beat
   always_ff @(posedge clock) begin
      pt_read_ff <= cmd.is_read;
      px_ff      <= px_in;
      py_ff      <= py_in;
      addr_ff    <= addr_full[AW-1:0];
      if (cmd.load_rsp) begin
         rsp_color_ff <= rd_hit_ff ? ram_rdata : '0;
         rsp_cnt_ff   <= cnt_ff;
      end
   end

   fbr_ram #(
      .WIDTH (COLOR_W),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock (clock),
      .we    (wr_ff),
      .re    (re_ff),
      .addr  (addr_ff),
      .wdata (color_ff),
      .rdata (ram_rdata)
   );

   assign status.r_zero    = (radius_ff == '0);
   assign status.x_end     = (cur_x_ff == x_hi_ff);
   assign status.y_end     = (cur_y_ff == y_hi_ff);
   assign status.root_more = (circ_y_ff != '0) && (t_ff >= v_ff);
   assign status.x_lt_y    = (circ_x_ff < CX_W'(circ_y_ff));
   assign status.x_eq_y    = (circ_x_ff == CX_W'(circ_y_ff));
   assign status.rsp_busy  = rsp_valid_ff && !rsp_ready;

   assign rsp_valid      = rsp_valid_ff;
   assign read_color     = rsp_color_ff;
   assign pixels_written = rsp_cnt_ff;

endmodule

// ===== rtl/core/framebuffer_raster_drawing_engine.sv =====
// Pixel write or read: emit the point, drain the pipeline, then load the response beat.
// Box and spans: set up, then scan the clamped box row by row, one pixel written per cycle.
// Circle: square the radius, emit four axis points, then per x step a root search and eight
// octant points, four where x meets y; the single point generator feeds the one RAM port.
// One command at a time; the response register lets the next request in before it is taken.
// Reset: synchronous; image size returns to 256 x 256, framebuffer left as is, no clear pass.
module framebuffer_raster_drawing_engine import fbr_pkg::*; #(
   parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
   input  logic             clock,
   input  logic             reset,
   fbr_req_if.sink          req,
   fbr_rsp_if.source        rsp,
   input  logic             csr_we,
   input  logic             csr_index,
   input  logic [REG_W-1:0] csr_wdata
);

   ctrl_cmd_type  cmd;
   dp_status_type status;

   fbr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_type  (req.req_type),
      .req_ready (req.ready),
      .status    (status),
      .cmd       (cmd)
   );

   fbr_datapath #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .req_type       (req.req_type),
      .x_a            (req.x_a),
      .y_a            (req.y_a),
      .x_b            (req.x_b),
      .y_b            (req.y_b),
      .radius         (req.radius),
      .color          (req.color),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .cmd            (cmd),
      .status         (status),
      .rsp_ready      (rsp.ready),
      .rsp_valid      (rsp.valid),
      .read_color     (rsp.read_color),
      .pixels_written (rsp.pixels_written)
   );

   // A command beat starts work; no second beat the next cycle
   a_one_cmd: assert property (@(posedge clock) disable iff (reset)
      req.valid && req.ready |=> !req.ready)
      else $error("request taken while a command is in progress");

   // Never overwrite a response still waiting
   a_rsp_free: assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |-> !status.rsp_busy)
      else $error("response loaded over a pending beat");

   // A response beat appears only from a load
   a_rsp_src: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp.valid) |-> $past(cmd.load_rsp))
      else $error("response valid without a load");

endmodule
